[hdl/ppd_pkg.sv]
// ppd_pkg: shared widths, constants and the control struct of the pulse peak
// detector with moving-average BPM. No dependencies.
`default_nettype none

package ppd_pkg;

  // History ring depth (moving-average window), legal range 1..32
  localparam int HISTORY_DEPTH = 8;

  localparam int SAMPLE_W = 32;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 32;
  localparam int BPM_W    = 26;

  localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W      = BPM_W + $clog2(HISTORY_DEPTH);

  // shared bit-serial divider
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [DIV_W-1:0] USEC_PER_MINUTE = 32'd60000000;

  // stream and config port widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_THRESHOLD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_THRESHOLD = 1'b1;

  localparam logic [THR_W-1:0] MIN_THRESHOLD_RST = 32'd100;
  localparam logic [THR_W-1:0] MAX_THRESHOLD_RST = 32'd2000;

  // controller -> history ring
  typedef struct packed {
    logic wr_en;      // store raw rate at current slot
    logic sum_start;  // start serial sum pass
  } hist_ctrl_t;

endpackage

`default_nettype wire

[hdl/ppd_serdiv.sv]
// ppd_serdiv: unsigned restoring divider, one quotient bit per cycle.
// Depends on ppd_pkg. Divisor must be nonzero.
`default_nettype none

module ppd_serdiv (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [ppd_pkg::DIV_W-1:0] dividend,
  input  wire logic [ppd_pkg::DIV_W-1:0] divisor,
  output logic                          done,
  output logic [ppd_pkg::DIV_W-1:0]     quotient
);
  import ppd_pkg::*;

  logic [DIV_W:0]     rem_r;
  logic [DIV_W-1:0]   quo_r;    // dividend bits shift out, quotient bits shift in
  logic [DIV_W-1:0]   dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIV_W:0]     trial;
  logic [DIV_W+1:0]   diff;
  logic               ge;

  assign trial = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = ~diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_W:0] : trial;
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[hdl/ppd_hist.sv]
// ppd_hist: BPM history ring with fill count and a serial sum pass that reads
// one entry per cycle. Depends on ppd_pkg.
`default_nettype none

module ppd_hist (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ppd_pkg::hist_ctrl_t        ctrl,
  input  wire logic [ppd_pkg::BPM_W-1:0]  wr_data,
  output logic                            sum_done,
  output logic [ppd_pkg::SUM_W-1:0]       sum,
  output logic [ppd_pkg::FILL_W-1:0]      filled
);
  import ppd_pkg::*;

  // entries at or above the fill count are never summed, so the store needs
  // no clearing pass on reset
  logic [BPM_W-1:0]      mem [HISTORY_DEPTH];
  logic [HIST_IDX_W-1:0] slot_r;
  logic [FILL_W-1:0]     filled_r;
  logic [FILL_W-1:0]     cnt_r;
  logic                  run_r;
  logic                  pend_r;
  logic                  done_r;
  logic [BPM_W-1:0]      rd_data_r;
  logic [SUM_W-1:0]      acc_r;
  logic                  issue;

  assign issue = run_r && (cnt_r < filled_r);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[slot_r] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[cnt_r[HIST_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      filled_r <= '0;
      cnt_r    <= '0;
      run_r    <= 1'b0;
      pend_r   <= 1'b0;
      done_r   <= 1'b0;
      acc_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.wr_en) begin
        slot_r <= (slot_r == HIST_IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                             : slot_r + HIST_IDX_W'(1);
        if (filled_r < FILL_W'(HISTORY_DEPTH)) begin
          filled_r <= filled_r + FILL_W'(1);
        end
      end
      if (ctrl.sum_start) begin
        run_r  <= 1'b1;
        cnt_r  <= '0;
        pend_r <= 1'b0;
        acc_r  <= '0;
      end else if (run_r) begin
        pend_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + FILL_W'(1);
        end
        if (pend_r) begin
          acc_r <= acc_r + SUM_W'(rd_data_r);
        end
        if (!issue && !pend_r) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sum_done = done_r;
  assign sum      = acc_r;
  assign filled   = filled_r;

endmodule

`default_nettype wire

[hdl/pulse_peak_detector_bpm_core.sv]
// Pulse peak detector with moving-average BPM: top level, peak state machine,
// config registers and output register. Depends on ppd_pkg, ppd_serdiv, ppd_hist.
//
// Usage:
//   in_*  : one sample per transfer; in_tdata = {time_us, sample}.
//   out_* : exactly one result per input; out_tdata = {peak_level,
//           average_bpm, beat}, zero padded to 64 bits.
//   cfg_* : write-only; cfg_addr 0 = min_threshold, 1 = max_threshold.
//           Write only while the block is idle.
// Sample flow:
//   One sample at a time; in_tready is high only in the idle state.
//   Non-beat sample: evaluated, then loaded into the output register.
//   Beat sample: two passes through the shared bit-serial divider (raw rate,
//   then mean) plus the one-entry-per-cycle history sum; a zero interval
//   skips the rate division.
// Reset (rst_n low, synchronous): thresholds back to 100 / 2000, detector
//   idle, history emptied and mean cleared, no result pending.
// Stall: the result sits in the output register until out_tready; the
//   next input is taken once the output register has been loaded, so one
//   sample can be in progress while a result waits.
`default_nettype none

module pulse_peak_detector_bpm_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream: [31:0] sample, [63:32] time_us
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ppd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // result stream: [0] beat, [26:1] average_bpm, [58:27] peak_level, rest 0
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ppd_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // config write port
  input  wire logic                                cfg_we,
  input  wire logic [ppd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [ppd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ppd_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_UP, PH_DOWN} phase_t;
  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_RAW, S_WRITE, S_SUM, S_MEAN, S_OUT}
    state_t;

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [THR_W-1:0]    min_thr_r, max_thr_r;
  logic [SAMPLE_W-1:0] smp_r, prev_r, peak_r;
  logic [TIME_W-1:0]   tim_r, rise_r, prior_r;
  logic [BPM_W-1:0]    raw_r, mean_r;
  logic                beat_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // datapath helpers
  logic                over_max;
  logic                rising;
  logic [TIME_W-1:0]   interval;
  logic                beat_now;
  logic                out_free;

  hist_ctrl_t          hist_ctrl;
  logic                sum_done;
  logic [SUM_W-1:0]    hist_sum;
  logic [FILL_W-1:0]   hist_filled;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend, div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;

  assign over_max = smp_r > max_thr_r;
  assign rising   = smp_r > prev_r;
  assign interval = rise_r - prior_r;
  assign beat_now = (state_r == S_EVAL) && !over_max && (phase_r == PH_UP) && !rising;
  assign out_free = !out_valid_r || out_tready;

  // divider is shared: raw rate first, then the mean
  always_comb begin
    div_start    = 1'b0;
    div_dividend = USEC_PER_MINUTE;
    div_divisor  = interval;
    if (beat_now && (interval != '0)) begin
      div_start = 1'b1;
    end else if ((state_r == S_SUM) && sum_done) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(hist_sum);
      div_divisor  = DIV_W'(hist_filled);
    end
  end

  assign hist_ctrl.wr_en     = (state_r == S_WRITE);
  assign hist_ctrl.sum_start = (state_r == S_WRITE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL: begin
        if (beat_now) begin
          state_nxt = (interval != '0) ? S_RAW : S_WRITE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RAW:   if (div_done) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_SUM;
      S_SUM:   if (sum_done) state_nxt = S_MEAN;
      S_MEAN:  if (div_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      min_thr_r   <= MIN_THRESHOLD_RST;
      max_thr_r   <= MAX_THRESHOLD_RST;
      prev_r      <= '0;
      rise_r      <= '0;
      prior_r     <= '0;
      peak_r      <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MIN_THRESHOLD: min_thr_r <= cfg_wdata;
          REG_MAX_THRESHOLD: max_thr_r <= cfg_wdata;
          default: ;
        endcase
      end

      if ((state_r == S_IDLE) && in_tvalid) begin
        smp_r <= in_tdata[SAMPLE_W-1:0];
        tim_r <= in_tdata[SAMPLE_W +: TIME_W];
      end

      if (state_r == S_EVAL) begin
        beat_r <= beat_now;
        if (over_max) begin
          // finger removed: drop tracking state, keep history and mean
          phase_r <= PH_IDLE;
          prev_r  <= '0;
          rise_r  <= '0;
          prior_r <= '0;
          peak_r  <= '0;
        end else begin
          unique case (phase_r)
            PH_UP: begin
              if (rising) begin
                rise_r <= tim_r;
                peak_r <= smp_r;
                prev_r <= smp_r;
              end else begin
                // beat; previous sample is left as is
                prior_r <= rise_r;
                phase_r <= PH_DOWN;
                raw_r   <= '0;
              end
            end
            PH_DOWN: begin
              if (smp_r < min_thr_r) phase_r <= PH_IDLE;
              prev_r <= smp_r;
            end
            default: begin
              phase_r <= (smp_r >= min_thr_r) ? PH_UP : PH_IDLE;
              prev_r  <= smp_r;
            end
          endcase
        end
      end

      if ((state_r == S_RAW) && div_done) begin
        raw_r <= div_quot[BPM_W-1:0];
      end
      if ((state_r == S_MEAN) && div_done) begin
        mean_r <= div_quot[BPM_W-1:0];
      end

      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= OUT_TDATA_W'({peak_r, mean_r, beat_r});
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  ppd_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  ppd_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (hist_ctrl),
    .wr_data  (raw_r),
    .sum_done (sum_done),
    .sum      (hist_sum),
    .filled   (hist_filled)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[hdl/ppd_chk.sv]
// ppd_chk: port-level checker for the pulse peak detector, bound to the top.
// Depends on ppd_pkg.
`default_nettype none

module ppd_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [ppd_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import ppd_pkg::*;

  logic             seen_r;
  logic [BPM_W-1:0] last_avg_r;
  logic [BPM_W-1:0] avg;
  logic             out_xfer;

  assign avg      = out_tdata[BPM_W:1];
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_xfer) begin
      seen_r     <= 1'b1;
      last_avg_r <= avg;
    end
  end

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one sample at a time: ready drops right after a sample transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while one is in progress");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // average only moves on a beat
  a_avg_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_tdata[0] && seen_r |-> avg == last_avg_r)
    else $error("average changed without a beat");

  // average never exceeds the one-microsecond-interval rate
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> BPM_W'(USEC_PER_MINUTE) >= avg)
    else $error("average out of range");

endmodule

bind pulse_peak_detector_bpm_core ppd_chk u_ppd_chk (.*);

`default_nettype wire

[sim/ppd_checker.sv]
// ppd_checker: watches the sample, result and config ports of the pulse peak
// detector, predicts each result from its own copy of the state and compares.
// Depends on ppd_pkg for widths, register indexes and the rate constant.
`timescale 1ns / 100ps

module ppd_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [ppd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [ppd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [ppd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [ppd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                   errors,
  output int                                   pending
);
  import ppd_pkg::*;

  typedef enum logic [1:0] {TRACK_IDLE, TRACK_RISE, TRACK_FALL} track_t;

  typedef struct packed {
    logic             beat;
    logic [BPM_W-1:0] bpm;
    logic [31:0]      peak;
  } bpm_result_t;

  // detector state
  bit [THR_W-1:0]    thr_min, thr_max;
  track_t            track;
  bit [31:0]         last_level, rise_stamp, beat_stamp, peak_val;
  bit [BPM_W-1:0]    rate_ring [HISTORY_DEPTH];
  int unsigned       ring_wr, ring_cnt;
  bit [BPM_W-1:0]    rate_avg;

  bpm_result_t       pending_results [$];
  bpm_result_t       want;
  logic [BPM_W-1:0]  got_bpm;
  logic [31:0]       got_peak;
  logic [OUT_TDATA_W-BPM_W-34:0] got_pad;
  int                mismatches = 0;

  // one sample through the peak tracker; returns the result it should cause
  function automatic bpm_result_t track_sample(bit [31:0] level, bit [31:0] stamp);
    bpm_result_t r;
    bit [31:0]   gap, rate;
    bit [63:0]   total;
    r.beat = 1'b0;
    if (level > thr_max) begin
      // finger off: tracking restarts, history kept
      track      = TRACK_IDLE;
      last_level = '0;
      rise_stamp = '0;
      beat_stamp = '0;
      peak_val   = '0;
    end else begin
      case (track)
        TRACK_RISE: begin
          if (level > last_level) begin
            rise_stamp = stamp;
            peak_val   = level;
            last_level = level;
          end else begin
            // peak passed: beat, last_level left alone
            gap        = rise_stamp - beat_stamp;
            beat_stamp = rise_stamp;
            rate       = (gap == 0) ? 32'd0 : USEC_PER_MINUTE / gap;
            rate_ring[ring_wr] = rate[BPM_W-1:0];
            total = '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) total += rate_ring[k];
            ring_wr = (ring_wr + 1) % HISTORY_DEPTH;
            if (ring_cnt < HISTORY_DEPTH) ring_cnt++;
            rate_avg = BPM_W'(total / ring_cnt);
            track    = TRACK_FALL;
            r.beat   = 1'b1;
          end
        end
        TRACK_FALL: begin
          if (level < thr_min) track = TRACK_IDLE;
          last_level = level;
        end
        default: begin
          track      = (level >= thr_min) ? TRACK_RISE : TRACK_IDLE;
          last_level = level;
        end
      endcase
    end
    r.bpm  = rate_avg;
    r.peak = peak_val;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_min    = MIN_THRESHOLD_RST;
      thr_max    = MAX_THRESHOLD_RST;
      track      = TRACK_IDLE;
      last_level = '0;
      rise_stamp = '0;
      beat_stamp = '0;
      peak_val   = '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) rate_ring[k] = '0;
      ring_wr    = 0;
      ring_cnt   = 0;
      rate_avg   = '0;
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIN_THRESHOLD: thr_min = cfg_wdata;
          REG_MAX_THRESHOLD: thr_max = cfg_wdata;
          default: ;
        endcase
      end
      // result side first: a transfer here belongs to the sample before
      if (out_tvalid && out_tready) begin
        got_bpm  = out_tdata[BPM_W:1];
        got_peak = out_tdata[BPM_W+32:BPM_W+1];
        got_pad  = out_tdata[OUT_TDATA_W-1:BPM_W+33];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transfer, tdata %h", $time, out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[0] !== want.beat || got_bpm !== want.bpm ||
              got_peak !== want.peak || got_pad !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch (exp/got) beat %0d/%0d bpm %0d/%0d peak %0d/%0d pad 0/%0h",
                       $time, want.beat, out_tdata[0], want.bpm, got_bpm,
                       want.peak, got_peak, got_pad);
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(track_sample(in_tdata[31:0], in_tdata[63:32]));
    end
    errors  <= mismatches;
    pending <= pending_results.size();
  end

endmodule

[sim/tb.sv]
// tb: stimulus and verdict for pulse_peak_detector_bpm_core. Drives sample
// transfers, random stalls and threshold writes; ppd_checker does the checking.
// Depends on ppd_pkg, the core RTL and sim/ppd_checker.sv.
`timescale 1ns / 100ps

module tb;
  import ppd_pkg::*;

  localparam int N_SETTINGS        = 6;
  localparam int ITEMS_PER_SETTING = 315;
  localparam int N_DIRECTED        = 25;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  wire logic              in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  wire logic              out_tvalid;
  logic                   out_tready = 1'b0;
  wire logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int errors;
  int pending;

  // threshold settings per phase; the first one is the reset pair
  bit [31:0] lo_set [N_SETTINGS] = '{32'd100, 32'd1, 32'hFFFF_FFFF,
                                     32'h0001_0000, 32'd0, 32'h8000_0000};
  bit [31:0] hi_set [N_SETTINGS] = '{32'd2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'h7FFF_FFFF, 32'd40, 32'h7FFF_FFFF};
  // idling mix, cycled over the phases
  int send_pct_set [4] = '{0, 49, 0, 18};
  int stall_pct_set [4] = '{0, 0, 49, 18};

  // directed walk at reset thresholds (100 / 2000): zero interval, level at
  // both thresholds, over-threshold clears, wrapped timestamps, interval of one
  bit [31:0] dir_level [N_DIRECTED] = '{
    32'd0, 32'd100, 32'd100, 32'd2000, 32'd99, 32'd2001, 32'hFFFF_FFFF,
    32'd150, 32'd300, 32'd2000, 32'd2000, 32'd500, 32'd50,
    32'd200, 32'd400, 32'd300, 32'd50,
    32'd120, 32'd130, 32'd130, 32'd0, 32'd150, 32'd151, 32'd100, 32'd2001};
  bit [31:0] dir_stamp [N_DIRECTED] = '{
    32'd0, 32'd0, 32'd10, 32'd20, 32'd30, 32'd40, 32'hFFFF_FFFF,
    32'd1000, 32'd2000, 32'd3000, 32'd4000, 32'd5000, 32'd6000,
    32'hFFFF_FF00, 32'h10, 32'h14, 32'h18,
    32'h20, 32'h21, 32'h22, 32'h23, 32'h24, 32'h22, 32'h25, 32'h26};

  bit [31:0] thr_lo, thr_hi;   // what the block currently holds
  bit [31:0] t_now, step_us;   // running timestamp, per-pulse sample spacing
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        items_sent     = 0;
  int        goal;

  pulse_peak_detector_bpm_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ppd_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side: random back-pressure at the current stall rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one sample transfer; random idle cycles ahead of it
  task automatic put_sample(input bit [31:0] level, input bit [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic emit(input bit [31:0] level);
    put_sample(level, t_now);
    t_now += step_us;
  endtask

  // sender holds off until every result is back, then lets the block settle
  task automatic quiesce(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // one well-formed pulse: baseline, rise, peak (beat), fall, back below min
  task automatic pulse_cycle();
    bit [31:0] lo, hi, lvl;
    int        n;
    lo = thr_lo;
    hi = (thr_hi < thr_lo) ? thr_lo : thr_hi;
    case ($urandom_range(15))
      0:       step_us = 0;
      1:       step_us = $urandom_range(40, 1);
      2:       step_us = $urandom();
      default: step_us = $urandom_range(15000, 3000);
    endcase
    // with min at zero the falling phase never ends by level; kick it idle
    if (lo == 0 && thr_hi != 32'hFFFF_FFFF)
      emit($urandom_range(32'hFFFF_FFFF, thr_hi + 1));
    if (lo != 0) repeat ($urandom_range(3, 1)) emit($urandom_range(lo - 1, 0));
    lvl = $urandom_range(lo + (hi - lo) / 4, lo);
    emit(lvl);
    n = $urandom_range(6, 1);
    repeat (n) begin
      if (lvl < hi) begin
        lvl += $urandom_range((hi - lvl) / 2 + 1, 1);
        emit(lvl);
      end
    end
    emit($urandom_range(lvl, lo));
    repeat ($urandom_range(3)) emit($urandom_range(hi, lo));
    if (lo != 0) emit($urandom_range(lo - 1, 0));
  endtask

  // stray samples: anywhere, over max, right at the thresholds
  task automatic noise_item();
    bit [31:0] lvl;
    case ($urandom_range(5))
      0: lvl = (thr_hi == 32'hFFFF_FFFF) ? $urandom()
                                         : $urandom_range(32'hFFFF_FFFF, thr_hi + 1);
      1: lvl = thr_lo;
      2: lvl = thr_lo - 1;
      3: lvl = thr_hi;
      4: lvl = thr_hi + 1;
      default: lvl = $urandom();
    endcase
    if ($urandom_range(7) == 0) t_now = $urandom();
    else t_now += $urandom_range(20000);
    put_sample(lvl, t_now);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    thr_lo = MIN_THRESHOLD_RST;
    thr_hi = MAX_THRESHOLD_RST;
    for (int i = 0; i < N_DIRECTED; i++) put_sample(dir_level[i], dir_stamp[i]);
    t_now = $urandom();

    for (int si = 0; si < N_SETTINGS; si++) begin
      quiesce(8);
      if (si != 0) begin
        // both registers back to back; the enable stays high across them
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MIN_THRESHOLD;
        cfg_wdata <= lo_set[si];
        @(posedge clk);
        cfg_addr  <= REG_MAX_THRESHOLD;
        cfg_wdata <= hi_set[si];
        @(posedge clk);
        cfg_we    <= 1'b0;
      end
      thr_lo = lo_set[si];
      thr_hi = hi_set[si];
      send_idle_pct   = send_pct_set[si % 4];
      recv_stall_pct <= stall_pct_set[si % 4];
      goal = items_sent + ITEMS_PER_SETTING;
      while (items_sent < goal) begin
        if ($urandom_range(9) < 2) repeat ($urandom_range(4, 1)) noise_item();
        else pulse_cycle();
      end
    end

    quiesce(100);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
